### design/aarch64_relocation_patcher_unit_defines.svh
// Assertion macros shared by the relocation patcher RTL.
// No dependencies; included by the top level.
`ifndef AARCH64_RELOCATION_PATCHER_UNIT_DEFINES_SVH
`define AARCH64_RELOCATION_PATCHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARP_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/arp_pkg.sv
// Shared types and codes for the relocation patcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package arp_pkg;

	// Relocation kind codes on the input
	localparam logic [4:0] ModeNone     = 5'd0;
	localparam logic [4:0] ModeAbs64    = 5'd1;
	localparam logic [4:0] ModeAbs32    = 5'd2;
	localparam logic [4:0] ModeAbs16    = 5'd3;
	localparam logic [4:0] ModePrel64   = 5'd4;
	localparam logic [4:0] ModePrel32   = 5'd5;
	localparam logic [4:0] ModePrel16   = 5'd6;
	localparam logic [4:0] ModeAdrLo21  = 5'd7;
	localparam logic [4:0] ModeAdrpHi21 = 5'd8;
	localparam logic [4:0] ModeAddLo12  = 5'd9;
	localparam logic [4:0] ModeLdst8    = 5'd10;
	localparam logic [4:0] ModeLdst16   = 5'd11;
	localparam logic [4:0] ModeLdst32   = 5'd12;
	localparam logic [4:0] ModeLdst64   = 5'd13;
	localparam logic [4:0] ModeLdst128  = 5'd14;
	localparam logic [4:0] ModeLdLo19   = 5'd15;
	localparam logic [4:0] ModeTbz14    = 5'd16;
	localparam logic [4:0] ModeCondBr19 = 5'd17;
	localparam logic [4:0] ModeCall26   = 5'd18;

	// Write widths in bytes
	localparam logic [3:0] WwNone = 4'd0;
	localparam logic [3:0] Ww2    = 4'd2;
	localparam logic [3:0] Ww4    = 4'd4;
	localparam logic [3:0] Ww8    = 4'd8;

	localparam int ArpQueueDepth = 2;

	// Internal kind classes, one per patch rule
	typedef enum logic [3:0] {
		K_NONE,
		K_ABS64,
		K_ABS32,
		K_ABS16,
		K_PREL64,
		K_PREL32,
		K_PREL16,
		K_ADR,
		K_ADRP,
		K_LO12,
		K_BR19,
		K_TBZ,
		K_B26,
		K_UNSUP
	} arp_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_UNSUP = 2'd2
	} arp_status_t;

	// One classified relocation as it sits in the queue
	typedef struct packed {
		arp_kind_t   kind;
		logic [2:0]  lo12_shift;
		logic [63:0] sa;
		logic [63:0] place;
		logic [63:0] old;
	} arp_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} arp_q_stat_t;

endpackage
`default_nettype wire

### design/arp_front.sv
// Front end: input register, S+A add and kind classification.
// Depends on arp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arp_front import arp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [255:0] s_tdata,
	input  wire logic [4:0]   s_tuser,
	input  wire arp_q_stat_t  q_stat,
	output logic              push,
	output arp_entry_t        entry
);

	logic       v_s1;
	arp_entry_t entry_s1;
	arp_entry_t cls;

	always_comb begin
		cls.sa         = s_tdata[127:64] + s_tdata[191:128];
		cls.place      = s_tdata[63:0];
		cls.old        = s_tdata[255:192];
		cls.lo12_shift = 3'd0;
		unique case (s_tuser)
			ModeNone:     cls.kind = K_NONE;
			ModeAbs64:    cls.kind = K_ABS64;
			ModeAbs32:    cls.kind = K_ABS32;
			ModeAbs16:    cls.kind = K_ABS16;
			ModePrel64:   cls.kind = K_PREL64;
			ModePrel32:   cls.kind = K_PREL32;
			ModePrel16:   cls.kind = K_PREL16;
			ModeAdrLo21:  cls.kind = K_ADR;
			ModeAdrpHi21: cls.kind = K_ADRP;
			ModeAddLo12, ModeLdst8:
				cls.kind = K_LO12;
			ModeLdst16, ModeLdst32, ModeLdst64, ModeLdst128: begin
				cls.kind       = K_LO12;
				cls.lo12_shift = 3'(s_tuser - ModeLdst8);
			end
			ModeLdLo19, ModeCondBr19:
				cls.kind = K_BR19;
			ModeTbz14:    cls.kind = K_TBZ;
			ModeCall26:   cls.kind = K_B26;
			default:      cls.kind = K_UNSUP;
		endcase
	end

	assign push     = v_s1 && !q_stat.full;
	assign s_tready = !v_s1 || !q_stat.full;
	assign entry    = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			entry_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

### design/arp_queue.sv
// Short FIFO between front and back end.
// Depends on arp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arp_queue import arp_pkg::*; #(
	parameter int DEPTH = ArpQueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire arp_entry_t  wr_entry,
	input  wire logic        pop,
	output arp_entry_t       rd_entry,
	output arp_q_stat_t      stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	arp_entry_t      mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CntW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

### design/arp_back.sv
// Back end: S+A-P, range checks, immediate insertion, output register.
// Depends on arp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module arp_back import arp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire arp_entry_t  rd_entry,
	input  wire arp_q_stat_t q_stat,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata
);

	logic [63:0] x;
	logic [51:0] pg;
	logic [11:0] lo12;
	logic [31:0] ins;
	logic [63:0] res;
	logic [3:0]  ww;
	arp_status_t st;
	logic        ok;

	logic        m_tvalid_q;
	logic [63:0] res_q;
	logic [3:0]  ww_q;
	arp_status_t st_q;

	assign x    = rd_entry.sa - rd_entry.place;
	// page difference, bits 63:12 only
	assign pg   = rd_entry.sa[63:12] - rd_entry.place[63:12];
	assign lo12 = rd_entry.sa[11:0] >> rd_entry.lo12_shift;

	always_comb begin
		res = rd_entry.old;
		ins = rd_entry.old[31:0];
		ww  = WwNone;
		st  = ST_OK;
		ok  = 1'b1;
		unique case (rd_entry.kind)
			K_NONE: begin
			end
			K_ABS64: begin
				res = rd_entry.sa;
				ww  = Ww8;
			end
			K_ABS32: begin
				ok  = ~|rd_entry.sa[63:32] | &rd_entry.sa[63:31];
				res = {rd_entry.old[63:32], rd_entry.sa[31:0]};
				ww  = Ww4;
			end
			K_ABS16: begin
				ok  = ~|rd_entry.sa[63:16] | &rd_entry.sa[63:15];
				res = {rd_entry.old[63:16], rd_entry.sa[15:0]};
				ww  = Ww2;
			end
			K_PREL64: begin
				res = x;
				ww  = Ww8;
			end
			K_PREL32: begin
				ok  = ~|x[63:31] | &x[63:31];
				res = {rd_entry.old[63:32], x[31:0]};
				ww  = Ww4;
			end
			K_PREL16: begin
				ok  = ~|x[63:15] | &x[63:15];
				res = {rd_entry.old[63:16], x[15:0]};
				ww  = Ww2;
			end
			K_ADR: begin
				ok          = ~|x[63:20] | &x[63:20];
				ins[30:29]  = x[1:0];
				ins[23:5]   = x[20:2];
				res         = {rd_entry.old[63:32], ins};
				ww          = Ww4;
			end
			K_ADRP: begin
				ok          = ~|pg[51:20] | &pg[51:20];
				ins[30:29]  = pg[1:0];
				ins[23:5]   = pg[20:2];
				res         = {rd_entry.old[63:32], ins};
				ww          = Ww4;
			end
			K_LO12: begin
				ins[21:10] = lo12;
				res        = {rd_entry.old[63:32], ins};
				ww         = Ww4;
			end
			K_BR19: begin
				ok        = (x[1:0] == 2'b00) && (~|x[63:20] | &x[63:20]);
				ins[23:5] = x[20:2];
				res       = {rd_entry.old[63:32], ins};
				ww        = Ww4;
			end
			K_TBZ: begin
				ok        = (x[1:0] == 2'b00) && (~|x[63:15] | &x[63:15]);
				ins[18:5] = x[15:2];
				res       = {rd_entry.old[63:32], ins};
				ww        = Ww4;
			end
			K_B26: begin
				ok        = (x[1:0] == 2'b00) && (~|x[63:27] | &x[63:27]);
				ins[25:0] = x[27:2];
				res       = {rd_entry.old[63:32], ins};
				ww        = Ww4;
			end
			default: begin
				st = ST_UNSUP;
			end
		endcase
		if (!ok) begin
			st = ST_RANGE;
		end
		// any failure leaves memory untouched
		if (st != ST_OK) begin
			res = rd_entry.old;
			ww  = WwNone;
		end
	end

	assign pop      = !q_stat.empty && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, st_q, ww_q, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
			ww_q  <= ww;
			st_q  <= st;
		end
	end

endmodule
`default_nettype wire

### design/aarch64_relocation_patcher_unit.sv
// AArch64 relocation patcher: one relocation in, one patched word out.
// Slave stream: s_tvalid/s_tready, s_tuser = relocation kind, s_tdata = P, S, A and the
//   current 64 bits at the place. Master stream: m_tvalid/m_tready, m_tdata = new
//   contents, byte count to store and status.
// A transfer happens on a rising edge with tvalid and tready both high.
// A result passes through the front register, a queue write and the output register
//   before it is presented.
// Throughput: one relocation per cycle sustained while m_tready stays high; the front
//   adds S+A, the back subtracts P, checks range/alignment and inserts the immediate.
// A queue of QUEUE_DEPTH entries sits between front and back, so the front keeps
//   taking transfers while a result waits on m_tready; once the queue and the front
//   register are full, s_tready drops until the receiver takes a result.
// Out-of-range, misaligned or unsupported relocations return the old contents with
//   a write width of zero.
// Reset (arst_n low) empties the front register, the queue and the output register;
//   relocations in flight are dropped and no stale result is shown after reset.
// Depends on arp_pkg, arp_front, arp_queue, arp_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "aarch64_relocation_patcher_unit_defines.svh"
module aarch64_relocation_patcher_unit import arp_pkg::*; #(
	parameter int QUEUE_DEPTH = ArpQueueDepth
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input relocation
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [63:0] place_address, [127:64] symbol_value, [191:128] addend, [255:192] old_contents
	input  wire logic [255:0] s_tdata,
	// [4:0] mode
	input  wire logic [4:0]   s_tuser,
	// patched result
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [63:0] new_contents, [67:64] write_width, [69:68] status, [71:70] zero
	output logic [71:0]       m_tdata
);

	arp_q_stat_t q_stat;
	arp_entry_t  push_entry;
	arp_entry_t  pop_entry;
	logic        push;
	logic        pop;

	// output fields, for the checks below
	logic [1:0]  out_st;
	logic [3:0]  out_ww;
	logic        out_ok;
	logic        out_err;
	logic        out_ww_legal;

	// Front: register the transfer, add S+A, classify the kind
	arp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.entry    (push_entry)
	);

	// Decoupling queue
	arp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (pop_entry),
		.stat     (q_stat)
	);

	// Back: checks, patching, output register
	arp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_entry (pop_entry),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	assign out_st       = m_tdata[69:68];
	assign out_ww       = m_tdata[67:64];
	assign out_ok       = m_tvalid && (out_st == ST_OK);
	assign out_err      = m_tvalid && (out_st != ST_OK);
	assign out_ww_legal = (out_ww == WwNone) || (out_ww == Ww2) || (out_ww == Ww4) ||
		(out_ww == Ww8);

	// A failed relocation must never ask for a store
	`ARP_ASSERT_HOLDS(a_err_no_write, clk, arst_n, out_err, out_ww == WwNone, "store on error")
	// Successful results store 0, 2, 4 or 8 bytes
	`ARP_ASSERT_HOLDS(a_ok_width, clk, arst_n, out_ok, out_ww_legal, "illegal write width")
	// Queue flags are exclusive
	`ARP_ASSERT_HOLDS(a_q_flags, clk, arst_n, 1'b1, !(q_stat.full && q_stat.empty), "queue flags")
	// A full queue loses at most one entry per cycle
	`ARP_ASSERT_NEXT(a_q_drain, clk, arst_n, q_stat.full, !q_stat.empty, "full queue drained")

endmodule
`default_nettype wire

### bench/reloc_patch_checker.sv
// Scoreboard for the AArch64 relocation patcher: predicts each patched word and compares.
// Depends on arp_pkg; instantiated by tb_aarch64_relocation_patcher_unit next to the DUT.
`timescale 1ns / 1ps
module reloc_patch_checker import arp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [255:0] s_tdata,
	input  logic [4:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	output int           mismatches,
	output int           pending
);

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] contents;
		logic [3:0]  width;
		logic [1:0]  status;
	} patch_result_t;

	patch_result_t expected_patches[$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// v read as signed fits in the given number of bits
	function automatic logic in_signed_range(input logic [63:0] v, input int nbits);
		logic [63:0] half;
		half = 64'd1 << (nbits - 1);
		return (v + half) < (64'd1 << nbits);
	endfunction

	// ADR/ADRP immediate: immlo in [30:29], immhi in [23:5]
	function automatic logic [63:0] with_adr_imm(input logic [63:0] word, input logic [63:0] imm);
		logic [63:0] w;
		w = word;
		w[30:29] = imm[1:0];
		w[23:5] = imm[20:2];
		return w;
	endfunction

	function automatic patch_result_t predict_patch(input logic [4:0] kind,
			input logic [63:0] p, input logic [63:0] s, input logic [63:0] a,
			input logic [63:0] old);
		patch_result_t r;
		logic [63:0] sa, x, page, res;
		logic ok;
		logic [2:0] sh;
		arp_status_t st;
		logic [3:0] width;
		sa = s + a;
		x = sa - p;
		res = old;
		width = WwNone;
		st = ST_OK;
		ok = 1'b1;
		case (kind)
			ModeNone: ;
			ModeAbs64: begin
				res = sa;
				width = Ww8;
			end
			ModeAbs32: begin
				// -2^31 .. 2^32-1
				ok = (sa + 64'h8000_0000) < 64'h1_8000_0000;
				res[31:0] = sa[31:0];
				width = Ww4;
			end
			ModeAbs16: begin
				ok = (sa + 64'h8000) < 64'h1_8000;
				res[15:0] = sa[15:0];
				width = Ww2;
			end
			ModePrel64: begin
				res = x;
				width = Ww8;
			end
			ModePrel32: begin
				ok = in_signed_range(x, 32);
				res[31:0] = x[31:0];
				width = Ww4;
			end
			ModePrel16: begin
				ok = in_signed_range(x, 16);
				res[15:0] = x[15:0];
				width = Ww2;
			end
			ModeAdrLo21: begin
				ok = in_signed_range(x, 21);
				res = with_adr_imm(old, x);
				width = Ww4;
			end
			ModeAdrpHi21: begin
				page = {sa[63:12], 12'h000} - {p[63:12], 12'h000};
				ok = in_signed_range(page, 33);
				res = with_adr_imm(old, page >> 12);
				width = Ww4;
			end
			ModeAddLo12, ModeLdst8, ModeLdst16, ModeLdst32, ModeLdst64, ModeLdst128: begin
				// scaled by access size for the ldst forms, never range checked
				sh = (kind >= ModeLdst8) ? 3'(kind - ModeLdst8) : 3'd0;
				res[21:10] = sa[11:0] >> sh;
				width = Ww4;
			end
			ModeLdLo19, ModeCondBr19: begin
				ok = (x[1:0] == 2'b00) && in_signed_range(x, 21);
				res[23:5] = x[20:2];
				width = Ww4;
			end
			ModeTbz14: begin
				ok = (x[1:0] == 2'b00) && in_signed_range(x, 16);
				res[18:5] = x[15:2];
				width = Ww4;
			end
			ModeCall26: begin
				ok = (x[1:0] == 2'b00) && in_signed_range(x, 28);
				res[25:0] = x[27:2];
				width = Ww4;
			end
			default: st = ST_UNSUP;
		endcase
		if (!ok)
			st = ST_RANGE;
		if (st != ST_OK) begin
			res = old;
			width = WwNone;
		end
		r.kind = kind;
		r.contents = res;
		r.width = width;
		r.status = st;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [4:0] kind,
			input logic [63:0] got, input logic [63:0] want);
		if (mismatches < 40)
			$display("%0t mismatch %s (kind %0d): got %h want %h", $realtime, what, kind,
				got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		patch_result_t want;
		if (arst_n) begin
			// results first: a result never leaves in the same cycle its input is taken, so no same-edge pairing
			if (m_tvalid && m_tready) begin
				if (expected_patches.size() == 0) begin
					report_mismatch("unexpected result", ModeNone, m_tdata[63:0], 64'd0);
				end else begin
					want = expected_patches.pop_front();
					if (m_tdata[63:0] !== want.contents)
						report_mismatch("new_contents", want.kind, m_tdata[63:0], want.contents);
					if (m_tdata[67:64] !== want.width)
						report_mismatch("write_width", want.kind, 64'(m_tdata[67:64]),
							64'(want.width));
					if (m_tdata[69:68] !== want.status)
						report_mismatch("status", want.kind, 64'(m_tdata[69:68]),
							64'(want.status));
					if (m_tdata[71:70] !== 2'b00)
						report_mismatch("pad bits", want.kind, 64'(m_tdata[71:70]), 64'd0);
				end
			end
			if (s_tvalid && s_tready)
				expected_patches.push_back(predict_patch(s_tuser, s_tdata[63:0],
					s_tdata[127:64], s_tdata[191:128], s_tdata[255:192]));
			pending <= expected_patches.size();
		end
	end

endmodule

### bench/tb_aarch64_relocation_patcher_unit.sv
// Stimulus and verdict for aarch64_relocation_patcher_unit: directed edge cases, then
// random relocations aimed at the range limits of each kind under varied stream idling.
// Depends on arp_pkg, the DUT and reloc_patch_checker.
`timescale 1ns / 1ps
module tb_aarch64_relocation_patcher_unit import arp_pkg::*;;

	localparam int CycleLimit = 200000;
	localparam int ItemsPerPhase = 338;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [255:0] s_tdata = '0;
	logic [4:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;

	int mismatches;
	int pending;
	int idle_pct = 0;   // chance the sender skips a cycle
	int stall_pct = 0;  // chance the receiver holds off
	int cycles = 0;

	aarch64_relocation_patcher_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	reloc_patch_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("FAIL aarch64_relocation_patcher_unit");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// One transfer on the slave side; tvalid stays high into the next item
	task automatic send_reloc(input logic [4:0] kind, input logic [63:0] p,
			input logic [63:0] s, input logic [63:0] a, input logic [63:0] old);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {old, a, s, p};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Aim S+A (absolute kinds) or S+A-P (pc-relative kinds) at value t,
	// with random S and P and the addend picked to land there
	task automatic send_target(input logic [4:0] kind, input longint t,
			input logic [63:0] old);
		logic [63:0] p, s, a;
		p = rand64();
		s = rand64();
		if (kind inside {ModeAbs64, ModeAbs32, ModeAbs16, ModeAddLo12, ModeLdst8, ModeLdst16,
				ModeLdst32, ModeLdst64, ModeLdst128})
			a = t - s;
		else
			a = t + p - s;
		send_reloc(kind, p, s, a, old);
	endtask

	initial begin
		logic [4:0] kind;
		logic [63:0] old;
		longint lo, hi, t, scale;
		int nbits, pick;
		logic aligned;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every kind, values at or just past the range limits
		send_reloc(ModeAbs64, 64'd0, '1, 64'h8000_0000_0000_0000, '1);
		send_reloc(ModePrel64, '1, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
		send_target(ModeNone, 64'd5, rand64());
		send_target(ModeAbs32, (longint'(1) << 32) - 1, '1);
		send_target(ModeAbs32, longint'(1) << 32, '1);
		send_target(ModeAbs32, -(longint'(1) << 31) - 1, rand64());
		send_target(ModeAbs16, -(longint'(1) << 15), '1);
		send_target(ModeAbs16, longint'(1) << 16, rand64());
		send_target(ModePrel32, -(longint'(1) << 31), 64'd0);
		send_target(ModePrel16, longint'(1) << 15, rand64());
		send_target(ModeAdrLo21, (longint'(1) << 20) - 1, 64'd0);
		send_target(ModeAdrpHi21, -(longint'(1) << 32), '1);
		send_target(ModeAddLo12, 64'hFFF, 64'd0);
		send_target(ModeLdst8, 64'hABC, '1);
		send_target(ModeLdst16, 64'hFFF, 64'd0);
		send_target(ModeLdst32, 64'h7F8, rand64());
		send_target(ModeLdst64, 64'hFF8, 64'd0);
		send_target(ModeLdst128, 64'hFF0, '1);
		send_target(ModeLdLo19, 64'd6, rand64());
		send_target(ModeTbz14, (longint'(1) << 15) - 4, 64'd0);
		send_target(ModeCondBr19, -(longint'(1) << 20), '1);
		send_target(ModeCall26, longint'(1) << 27, rand64());
		send_target(5'd19, 64'd0, rand64());
		send_target(5'd31, 64'd0, '1);

		// Random: no idling, sender gaps, receiver stalls, then both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 74; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 74; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			for (int n = 0; n < ItemsPerPhase; n++) begin
				kind = ($urandom_range(99) < 88) ? 5'($urandom_range(18))
					: 5'($urandom_range(31, 19));
				lo = 0;
				hi = 0;
				nbits = 0;
				scale = 1;
				aligned = 1'b0;
				case (kind)
					ModeAbs32: begin
						lo = -(longint'(1) << 31);
						hi = (longint'(1) << 32) - 1;
					end
					ModeAbs16: begin
						lo = -(longint'(1) << 15);
						hi = (longint'(1) << 16) - 1;
					end
					ModePrel32: nbits = 32;
					ModePrel16: nbits = 16;
					ModeAdrLo21: nbits = 21;
					ModeAdrpHi21: begin
						// page delta limit, stepped a page at a time near the edges
						nbits = 33;
						scale = 4096;
					end
					ModeLdLo19, ModeCondBr19: begin
						nbits = 21;
						aligned = 1'b1;
					end
					ModeTbz14: begin
						nbits = 16;
						aligned = 1'b1;
					end
					ModeCall26: begin
						nbits = 28;
						aligned = 1'b1;
					end
					default: ;
				endcase
				if (nbits != 0) begin
					lo = -(longint'(1) << (nbits - 1));
					hi = (longint'(1) << (nbits - 1)) - 1;
				end
				pick = $urandom_range(9);
				if (hi == lo || pick >= 8)
					t = longint'(rand64());
				else if (pick < 2)
					t = hi + scale * (int'($urandom_range(8)) - 4);
				else if (pick < 4)
					t = lo + scale * (int'($urandom_range(8)) - 4);
				else
					t = lo + longint'(rand64() % 64'(hi - lo + 1));
				// branch targets are mostly word aligned
				if (aligned && $urandom_range(3) != 0)
					t = t & ~longint'(3);
				case ($urandom_range(7))
					0: old = '1;
					1: old = 64'd0;
					default: old = rand64();
				endcase
				send_target(kind, t, old);
			end
		end
		s_tvalid <= 1'b0;

		// let the checker see the last transfer, then drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS aarch64_relocation_patcher_unit");
		else
			$display("FAIL aarch64_relocation_patcher_unit");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/arp_pkg.sv
design/arp_front.sv
design/arp_queue.sv
design/arp_back.sv
design/aarch64_relocation_patcher_unit.sv
bench/reloc_patch_checker.sv
bench/tb_aarch64_relocation_patcher_unit.sv
